@@ hw/rtl/clc_pkg.sv @@
// shared types and codes for the circular list engine
package clc_pkg;

  // action codes carried by an input transaction
  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_SEARCH  = 2'd2,
    ACT_REVERSE = 2'd3
  } act_t;

  // status codes carried by a result transaction
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } stat_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    act_t                      action;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    stat_t              status;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage

@@ hw/rtl/clc_mem.sv @@
// entry store: one write port, one read port with registered read data
module clc_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [clc_pkg::VALUE_W-1:0]  wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [clc_pkg::VALUE_W-1:0]  rdata
);
  import clc_pkg::*;

  logic [VALUE_W-1:0] entries_r [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      entries_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= entries_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/clc_ctrl.sv @@
// sequencer: walks the entry store for each action and builds the result
module clc_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  clc_pkg::in_item_t           in_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output clc_pkg::out_item_t          res_data,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [clc_pkg::VALUE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [clc_pkg::VALUE_W-1:0] mem_rdata
);
  import clc_pkg::*;

  localparam logic [AW:0]   CAP_W = (AW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  act_t               act_r, act_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic               dir_r, dir_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               hit_r, hit_nxt;
  out_item_t          res_r, res_nxt;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_p1;
  logic               match;

  // logical position to physical address: base plus or minus index, modulo capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] idx,
                                         input logic [AW-1:0] base,
                                         input logic          dir);
    logic [AW:0] sum;
    logic [AW:0] sum_wrap;
    logic [AW:0] dif;
    logic [AW:0] dif_wrap;
    begin
      sum      = {1'b0, base} + {1'b0, idx};
      sum_wrap = sum - CAP_W;
      dif      = {1'b0, base} - {1'b0, idx};
      dif_wrap = dif + CAP_W;
      if (!dir) begin
        phys = (sum >= CAP_W) ? sum_wrap[AW-1:0] : sum[AW-1:0];
      end else begin
        phys = (base < idx) ? dif_wrap[AW-1:0] : dif[AW-1:0];
      end
    end
  endfunction

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_p1 = count_r + CW'(1);
  assign match  = (mem_rdata == key_r);

  // next-state logic
  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    count_nxt   = count_r;
    base_nxt    = base_r;
    dir_nxt     = dir_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    rd_pend_nxt = rd_pend_r;
    hit_nxt     = hit_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_data.action;
          key_nxt     = in_data.value;
          hit_nxt     = 1'b0;
          rd_idx_nxt  = '0;
          rd_pend_nxt = 1'b0;
          if (in_data.action inside {ACT_INSERT, ACT_REVERSE}) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_EXEC: begin
        res_nxt.found = 1'b0;
        if (act_r == ACT_INSERT) begin
          if (count_r < CAP_C) begin
            // append at the tail position
            mem_we              = 1'b1;
            mem_waddr           = phys(count_r[AW-1:0], base_r, dir_r);
            mem_wdata           = key_r;
            count_nxt           = cnt_p1;
            res_nxt.status      = ST_DONE;
            res_nxt.entry_count = COUNT_W'(cnt_p1);
          end else begin
            res_nxt.status      = ST_FULL;
            res_nxt.entry_count = COUNT_W'(count_r);
          end
        end else begin
          // reverse: old tail becomes head, walking direction flips
          if (count_r != '0) begin
            base_nxt = phys(cnt_m1[AW-1:0], base_r, dir_r);
            dir_nxt  = ~dir_r;
          end
          res_nxt.status      = ST_DONE;
          res_nxt.entry_count = COUNT_W'(count_r);
        end
        state_nxt = S_DONE;
      end

      S_SCAN: begin
        // issue the next read, one entry per cycle
        if (rd_idx_r < count_r) begin
          mem_re      = 1'b1;
          mem_raddr   = phys(rd_idx_r[AW-1:0], base_r, dir_r);
          cmp_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end

        // compare returned data; delete closes the gap behind the walk
        if (rd_pend_r) begin
          if (act_r == ACT_DELETE) begin
            if (hit_r) begin
              mem_we    = 1'b1;
              mem_waddr = phys(cmp_idx_r - AW'(1), base_r, dir_r);
              mem_wdata = mem_rdata;
            end else if (match) begin
              hit_nxt = 1'b1;
            end
          end else if (match) begin
            res_nxt.found       = 1'b1;
            res_nxt.status      = ST_DONE;
            res_nxt.entry_count = COUNT_W'(count_r);
            state_nxt           = S_DONE;
          end
        end else if (rd_idx_r == count_r) begin
          // walk finished with nothing outstanding
          if (act_r == ACT_DELETE) begin
            res_nxt.found = hit_r;
            if (hit_r) begin
              count_nxt           = cnt_m1;
              res_nxt.status      = ST_DONE;
              res_nxt.entry_count = COUNT_W'(cnt_m1);
            end else begin
              res_nxt.status      = ST_ABSENT;
              res_nxt.entry_count = COUNT_W'(count_r);
            end
          end else begin
            res_nxt.found       = 1'b0;
            res_nxt.status      = ST_DONE;
            res_nxt.entry_count = COUNT_W'(count_r);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      base_r    <= '0;
      dir_r     <= 1'b0;
      rd_pend_r <= 1'b0;
      hit_r     <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      base_r    <= base_nxt;
      dir_r     <= dir_nxt;
      rd_pend_r <= rd_pend_nxt;
      hit_r     <= hit_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

endmodule

@@ hw/rtl/circular_list_engine_top.sv @@
// top level of the circular list engine: sequencer, entry store and result register
//
// Holds an ordered list of up to CAPACITY 32-bit values in a single-port-read,
// single-port-write memory addressed as a ring: a head pointer and a walking
// direction map list positions to addresses, so reverse only moves the head
// to the old tail and flips the direction. One transaction is worked on at a
// time. Insert and reverse go from acceptance through an execute state to the
// result being offered. Search and delete walk the list through the memory
// read port, which reads one entry per cycle; search stops at the first match
// and a delete writes each later entry one place back behind the walk. The
// result register lets the next transaction be accepted while a result waits
// to be taken. The memory needs no clearing pass after reset: only entries
// below the entry count are ever read.
module circular_list_engine_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clc_pkg::out_item_t out_data
);
  import clc_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic               res_valid;
  logic               res_ready;
  out_item_t          res_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  clc_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  clc_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register: free when empty or being taken this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one transaction in flight: acceptance closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a found key never comes with a failure status
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ST_DONE)
    else $error("found with non-done status");

  // full is reported only at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == COUNT_W'(CAPACITY))
    else $error("full status below capacity");

  // entry count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127 || out_data.entry_count <= COUNT_W'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

@@ dv/tb_circular_list_engine_top.sv @@
// self-checking testbench for the circular list engine: directed and random list operations
`timescale 1ns / 100ps

module tb_circular_list_engine_top;
  import clc_pkg::*;

  localparam int unsigned LIST_CAP = 64;
  localparam int unsigned ITEMS_PER_PHASE = 330;

  // shadow list and queue of expected results, fed by accepted transactions
  class list_scoreboard;
    logic [VALUE_W-1:0] seq[$];
    out_item_t          awaited[$];
    int unsigned        errors;
    int unsigned        n_results;
    int unsigned        cap;

    function new(int unsigned cap_i);
      cap = cap_i;
      errors = 0;
      n_results = 0;
    endfunction

    function int find_key(logic [VALUE_W-1:0] key);
      for (int i = 0; i < seq.size(); i++) begin
        if (seq[i] == key) return i;
      end
      return -1;
    endfunction

    function int unsigned depth();
      return seq.size();
    endfunction

    function logic [VALUE_W-1:0] entry_at(int unsigned idx);
      return seq[idx];
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // apply an accepted transaction to the shadow list and queue its result
    function void note_request(in_item_t req);
      out_item_t          res;
      int                 idx;
      int                 lo;
      int                 hi;
      logic [VALUE_W-1:0] tmp;
      res.found = 1'b0;
      res.status = ST_DONE;
      case (req.action)
        ACT_INSERT: begin
          if (seq.size() < cap) seq.push_back(req.value);
          else res.status = ST_FULL;
        end
        ACT_DELETE: begin
          idx = find_key(req.value);
          if (idx >= 0) begin
            res.found = 1'b1;
            seq.delete(idx);
          end else begin
            res.status = ST_ABSENT;
          end
        end
        ACT_SEARCH: begin
          res.found = (find_key(req.value) >= 0);
        end
        ACT_REVERSE: begin
          lo = 0;
          hi = seq.size() - 1;
          while (lo < hi) begin
            tmp = seq[lo];
            seq[lo] = seq[hi];
            seq[hi] = tmp;
            lo++;
            hi--;
          end
        end
        default: ;
      endcase
      res.entry_count = COUNT_W'(seq.size());
      awaited.push_back(res);
    endfunction

    // compare a result transaction with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %0d: found %0b status %0d count %0d",
                   n_results, got.found, got.status, got.entry_count);
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found || got.status !== want.status ||
          got.entry_count !== want.entry_count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: found exp %0b got %0b, status exp %0d got %0d, count exp %0d got %0d",
                   n_results, want.found, got.found, want.status, got.status,
                   want.entry_count, got.entry_count);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int unsigned    tx_idle = 0;
  int unsigned    rx_stall = 0;
  bit             filling = 1'b1;
  list_scoreboard sb = new(LIST_CAP);

  circular_list_engine_top #(.CAPACITY(LIST_CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall);
  end

  // result sampling
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // offer one transaction, returning on the falling edge after it is taken
  task automatic send_item(input in_item_t req);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_op(input act_t act, input logic [VALUE_W-1:0] val);
    in_item_t req;
    req.action = act;
    req.value = val;
    send_item(req);
  endtask

  // hold the sender off until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // value for an operation: repeated small pool, stored entries or full-range noise
  function automatic logic [VALUE_W-1:0] pick_value(input bit is_key);
    logic [VALUE_W-1:0] pool[8];
    int unsigned        r;
    pool = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h5555_5555};
    r = $urandom_range(0, 9);
    if (is_key && r < 7 && sb.depth() > 0)
      return sb.entry_at($urandom_range(0, sb.depth() - 1));
    if (r < 6) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // random transaction: alternates between filling the list and draining it
  function automatic in_item_t make_item();
    in_item_t    req;
    int unsigned r;
    if (filling && sb.depth() >= LIST_CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
    if (!filling && sb.depth() == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 65) req.action = ACT_INSERT;
      else if (r < 77) req.action = ACT_DELETE;
      else if (r < 92) req.action = ACT_SEARCH;
      else req.action = ACT_REVERSE;
    end else begin
      if (r < 10) req.action = ACT_INSERT;
      else if (r < 80) req.action = ACT_DELETE;
      else if (r < 92) req.action = ACT_SEARCH;
      else req.action = ACT_REVERSE;
    end
    req.value = pick_value(req.action != ACT_INSERT);
    return req;
  endfunction

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, extremes, duplicates, reverse of empty, single-entry and odd lengths
    send_op(ACT_SEARCH, 32'd5);
    send_op(ACT_DELETE, 32'd5);
    send_op(ACT_REVERSE, 32'hFFFF_FFFF);
    send_op(ACT_INSERT, 32'h8000_0000);
    send_op(ACT_REVERSE, 32'h0);
    send_op(ACT_INSERT, 32'h7FFF_FFFF);
    send_op(ACT_INSERT, 32'h0);
    send_op(ACT_INSERT, 32'hFFFF_FFFF);
    send_op(ACT_INSERT, 32'h0);
    send_op(ACT_SEARCH, 32'h0);
    send_op(ACT_SEARCH, 32'h8000_0000);
    send_op(ACT_SEARCH, 32'd12345);
    send_op(ACT_REVERSE, 32'h0);
    send_op(ACT_DELETE, 32'h0);
    send_op(ACT_DELETE, 32'h7FFF_FFFF);
    send_op(ACT_DELETE, 32'd42);
    send_op(ACT_SEARCH, 32'h0);
    send_op(ACT_INSERT, 32'hAAAA_AAAA);
    send_op(ACT_INSERT, 32'h5555_5555);
    send_op(ACT_REVERSE, 32'h0);
    send_op(ACT_DELETE, 32'h5555_5555);
    send_op(ACT_DELETE, 32'h8000_0000);
    wait_drained();

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle = 0;  rx_stall = 0;  end
        1: begin tx_idle = 71; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 71; end
        default: begin tx_idle = 9; rx_stall = 9; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(make_item());
      wait_drained();
    end

    // let the block settle, then report
    rx_stall = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LIST_CAP + 16) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
